FILE: rtl/aligned_bump_region_allocator_assert.svh
// Assertion macros for the aligned bump region allocator.
// Used by the top level; expects clk and rst_n in scope.
`ifndef ALIGNED_BUMP_REGION_ALLOCATOR_ASSERT_SVH
`define ALIGNED_BUMP_REGION_ALLOCATOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ABRA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ABRA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/abra_pkg.sv
// Shared types, widths and codes of the aligned bump region allocator.
// No dependencies; imported by the top level, abra_front and abra_back.
package abra_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int ALIGN_SHIFT = 21;
  localparam int ADDR_BITS   = 48;

  localparam int ADDR_W = 48;
  localparam int UNIT_W = 27;
  localparam int TAG_W  = 8;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 3;

  // block counts: pool end may reach one past the unit field range
  localparam int END_W  = UNIT_W + 1;
  localparam int WANT_W = ADDR_W - ALIGN_SHIFT + 1;
  localparam int SZ_W   = (WANT_W > END_W) ? WANT_W : END_W;
  localparam int UB_W   = SZ_W + 1;
  localparam int WIDE_W = UB_W + ALIGN_SHIFT;
  localparam int QEND_W = ADDR_W + 1;

  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [63:0]       ADDR_UNIT_LIMIT = 64'd1 << (ADDR_BITS - ALIGN_SHIFT);
  localparam logic [ADDR_W-1:0] ADDR_MAX        = '1;
  localparam logic [SZ_W-1:0]   SAT_UNITS       = SZ_W'(ADDR_MAX >> ALIGN_SHIFT);
  localparam logic [QEND_W-1:0] ROUND_ADD       = QEND_W'((64'd1 << ALIGN_SHIFT) - 64'd1);

  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POOL_BASE = 1'b0,
    REG_POOL_SIZE = 1'b1
  } cfg_reg_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_CARVE = 2'd0,
    CMD_FIND  = 2'd1,
    CMD_CHECK = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_UNINIT    = 3'd1;
  localparam logic [STAT_W-1:0] ST_ZERO      = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STAT_W-1:0] ST_EXHAUSTED = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] req_bytes;
    logic [TAG_W-1:0]  owner_id;
    logic [TAG_W-1:0]  region_kind;
    logic [ADDR_W-1:0] query_base;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              hit;
    logic [ADDR_W-1:0] region_base;
    logic [ADDR_W-1:0] region_size;
    logic [ADDR_W-1:0] shortfall;
    logic [ADDR_W-1:0] remaining_bytes;
    logic [ADDR_W-1:0] used_bytes;
  } out_item_t;

  // classified command as it leaves the front end
  typedef struct packed {
    cmd_t              op;
    logic              bytes_zero;
    logic [SZ_W-1:0]   want_units;
    logic [ADDR_W-1:0] qbase;
    logic [QEND_W-1:0] qend;
    logic [TAG_W-1:0]  owner;
    logic [TAG_W-1:0]  kind;
  } work_t;

  typedef struct packed {
    logic  valid;
    work_t item;
  } qhead_t;

  typedef struct packed {
    logic [END_W-1:0] base_units;
    logic [SZ_W-1:0]  size_units;
    logic [TAG_W-1:0] owner;
    logic [TAG_W-1:0] kind;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // block count to byte address, wide enough to never overflow
  function automatic logic [WIDE_W-1:0] to_bytes(input logic [UB_W-1:0] units);
    return WIDE_W'(units) << ALIGN_SHIFT;
  endfunction

endpackage

FILE: rtl/aligned_bump_region_allocator.sv
// Top level of the aligned bump region allocator: front end, command queue
// and back end. Depends on abra_pkg, abra_front, abra_back and the assert header.
//
// A command beat is taken when start is high and busy is low; busy rises only
// while the two-entry command queue is full. Each command yields exactly one
// result, shown on out_item for a single cycle with out_valid high; there is
// no backpressure, so the receiver must take it then. A taken command waits in
// the queue until the sequencer, which handles one command at a time, is idle.
// Carve and no-op then pass the evaluate and finish states and the output
// register; find and range check also pass the scan state, where the single-read
// table RAM yields one entry per cycle up to a match or the table's end (at most
// 16; none if the table is empty or a check range is empty or leaves the pool).
// Configuration writes apply at once and must come only while no command is
// in flight; writing the pool base empties the table. No clearing pass.
module aligned_bump_region_allocator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  abra_pkg::in_item_t              in_item,
  output logic                            out_valid,
  output abra_pkg::out_item_t             out_item,
  input  logic                            cfg_we,
  input  logic [abra_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [abra_pkg::UNIT_W-1:0]     cfg_wdata
);
  import abra_pkg::*;

`include "aligned_bump_region_allocator_assert.svh"

  qhead_t head;
  logic   pop;

  abra_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .head    (head),
    .pop     (pop)
  );

  abra_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  `ABRA_ASSERT_NXT(a_strobe_single, out_valid, !out_valid, "result strobe longer than a cycle")
  `ABRA_ASSERT_NXT(a_push_queued, start && !busy, head.valid, "taken beat missing from queue")
  `ABRA_ASSERT_IMP(a_err_no_region, out_valid && out_item.status != ST_OK,
    !out_item.hit && out_item.region_base == '0, "failed carve reports a region")
  `ABRA_ASSERT_IMP(a_exh_shortfall, out_valid && out_item.status == ST_EXHAUSTED,
    out_item.shortfall != '0, "exhausted carve without shortfall")

endmodule

FILE: rtl/abra_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the region table.
module abra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/abra_front.sv
// Front end: takes command beats, rounds the carve size, forms the range end,
// and queues classified commands for the back end. Depends on abra_pkg.
module abra_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  abra_pkg::in_item_t in_item,
  output abra_pkg::qhead_t   head,
  input  logic               pop
);
  import abra_pkg::*;

  work_t               q_mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                push;
  logic [QEND_W-1:0]   round_sum;
  work_t               cls;

  assign busy = (cnt_r == QCNT_W'(QDEPTH));
  assign push = start & ~busy;

  always_comb begin
    round_sum      = {1'b0, in_item.req_bytes} + ROUND_ADD;
    cls.op         = cmd_t'(in_item.cmd);
    cls.bytes_zero = (in_item.req_bytes == '0);
    cls.want_units = SZ_W'(round_sum >> ALIGN_SHIFT);
    cls.qbase      = in_item.query_base;
    cls.qend       = {1'b0, in_item.query_base} + {1'b0, in_item.req_bytes};
    cls.owner      = in_item.owner_id;
    cls.kind       = in_item.region_kind;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + QCNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - QCNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls;
    end
  end

  assign head.valid = (cnt_r != '0);
  assign head.item  = q_mem_r[rd_ptr_r];

endmodule

FILE: rtl/abra_back.sv
// Back end: pool registers, cursor, region table and the command sequencer
// that carves, scans the table and issues the result strobe.
// Depends on abra_pkg and abra_ram.
module abra_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [abra_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [abra_pkg::UNIT_W-1:0]     cfg_wdata,
  input  abra_pkg::qhead_t                head,
  output logic                            pop,
  output logic                            out_valid,
  output abra_pkg::out_item_t             out_item
);
  import abra_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_SCAN = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [UNIT_W-1:0]   pool_base_r, pool_base_nxt;
  logic [UNIT_W-1:0]   pool_size_r, pool_size_nxt;
  logic [END_W-1:0]    cursor_r, cursor_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  work_t               cur_r, cur_nxt;
  logic [END_W-1:0]    avail_r;
  logic [END_W-1:0]    end_raw_r;
  logic [STAT_W-1:0]   status_r, status_nxt;
  logic                hit_r, hit_nxt;
  logic [ADDR_W-1:0]   rbase_r, rbase_nxt;
  logic [ADDR_W-1:0]   rsize_r, rsize_nxt;
  logic [ADDR_W-1:0]   short_r, short_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_item_r, out_item_nxt;

  logic [END_W-1:0]    end_raw, end_cap, avail_c;
  logic [SZ_W-1:0]     have, lack;
  logic                range_ok;
  logic                owner_eq, kind_eq, in_entry, last;
  entry_t              ent, wr_ent;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic                ram_we;
  logic [IDX_W-1:0]    ram_raddr;

  // usable pool end, capped to the address space
  always_comb begin
    end_raw = END_W'(pool_base_r) + END_W'(pool_size_r);
    end_cap = (64'(end_raw) > ADDR_UNIT_LIMIT) ? END_W'(ADDR_UNIT_LIMIT) : end_raw;
    avail_c = (pool_size_r == '0 || cursor_r >= end_cap) ? '0 : end_cap - cursor_r;
  end

  always_comb begin
    have     = SZ_W'(avail_r);
    lack     = cur_r.want_units - have;
    range_ok = !cur_r.bytes_zero
             && (WIDE_W'(cur_r.qbase) >= to_bytes(UB_W'(pool_base_r)))
             && (WIDE_W'(cur_r.qend) <= to_bytes(UB_W'(end_raw_r)));
    ent      = entry_t'(ram_rdata);
    owner_eq = (ent.owner == cur_r.owner);
    kind_eq  = (ent.kind == cur_r.kind);
    in_entry = (WIDE_W'(cur_r.qbase) >= to_bytes(UB_W'(ent.base_units)))
             && (WIDE_W'(cur_r.qend)
                 <= to_bytes(UB_W'(ent.base_units) + UB_W'(ent.size_units)));
    last     = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
    wr_ent.base_units = cursor_r;
    wr_ent.size_units = cur_r.want_units;
    wr_ent.owner      = cur_r.owner;
    wr_ent.kind       = cur_r.kind;
  end

  always_comb begin
    state_nxt     = state_r;
    pool_base_nxt = pool_base_r;
    pool_size_nxt = pool_size_r;
    cursor_nxt    = cursor_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    cur_nxt       = cur_r;
    status_nxt    = status_r;
    hit_nxt       = hit_r;
    rbase_nxt     = rbase_r;
    rsize_nxt     = rsize_r;
    short_nxt     = short_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    pop           = 1'b0;
    ram_we        = 1'b0;
    ram_raddr     = '0;

    case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          pop        = 1'b1;
          cur_nxt    = head.item;
          status_nxt = ST_OK;
          hit_nxt    = 1'b0;
          rbase_nxt  = '0;
          rsize_nxt  = '0;
          short_nxt  = '0;
          state_nxt  = S_EVAL;
        end
      end
      S_EVAL: begin
        idx_nxt   = '0;
        state_nxt = S_FIN;
        case (cur_r.op)
          CMD_CARVE: begin
            if (pool_size_r == '0) begin
              status_nxt = ST_UNINIT;
            end else if (cur_r.bytes_zero) begin
              status_nxt = ST_ZERO;
            end else if (count_r >= CNT_W'(MAX_ENTRIES)) begin
              status_nxt = ST_FULL;
            end else if (cur_r.want_units > have) begin
              status_nxt = ST_EXHAUSTED;
              short_nxt  = (lack > SAT_UNITS) ? ADDR_MAX : ADDR_W'(to_bytes(UB_W'(lack)));
            end else begin
              ram_we     = 1'b1;
              rbase_nxt  = ADDR_W'(to_bytes(UB_W'(cursor_r)));
              rsize_nxt  = ADDR_W'(to_bytes(UB_W'(cur_r.want_units)));
              cursor_nxt = cursor_r + END_W'(cur_r.want_units);
              count_nxt  = count_r + CNT_W'(1);
            end
          end
          CMD_FIND: begin
            if (count_r != '0) begin
              state_nxt = S_SCAN;
            end
          end
          CMD_CHECK: begin
            if (count_r != '0 && range_ok) begin
              state_nxt = S_SCAN;
            end
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_SCAN: begin
        // read data holds entry idx_r; fetch the next one meanwhile
        ram_raddr = idx_r + IDX_W'(1);
        if (cur_r.op == CMD_FIND && owner_eq && kind_eq) begin
          hit_nxt   = 1'b1;
          rbase_nxt = ADDR_W'(to_bytes(UB_W'(ent.base_units)));
          rsize_nxt = ADDR_W'(to_bytes(UB_W'(ent.size_units)));
          state_nxt = S_FIN;
        end else if (cur_r.op == CMD_CHECK && owner_eq && in_entry) begin
          hit_nxt   = 1'b1;
          state_nxt = S_FIN;
        end else if (last) begin
          state_nxt = S_FIN;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_FIN: begin
        out_valid_nxt                = 1'b1;
        out_item_nxt.status          = status_r;
        out_item_nxt.hit             = hit_r;
        out_item_nxt.region_base     = rbase_r;
        out_item_nxt.region_size     = rsize_r;
        out_item_nxt.shortfall       = short_r;
        out_item_nxt.remaining_bytes = ADDR_W'(to_bytes(UB_W'(avail_c)));
        out_item_nxt.used_bytes      = (cursor_r >= END_W'(pool_base_r))
          ? ADDR_W'(to_bytes(UB_W'(cursor_r - END_W'(pool_base_r)))) : '0;
        state_nxt                    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // the user must write config only while idle; the block does not enforce it
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_POOL_BASE: begin
          pool_base_nxt = cfg_wdata;
          cursor_nxt    = END_W'(cfg_wdata);
          count_nxt     = '0;
        end
        REG_POOL_SIZE: begin
          pool_size_nxt = cfg_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pool_base_r <= '0;
      pool_size_r <= '0;
      cursor_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pool_base_r <= pool_base_nxt;
      pool_size_r <= pool_size_nxt;
      cursor_r    <= cursor_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    cur_r      <= cur_nxt;
    avail_r    <= avail_c;
    end_raw_r  <= end_raw;
    status_r   <= status_nxt;
    hit_r      <= hit_nxt;
    rbase_r    <= rbase_nxt;
    rsize_r    <= rsize_nxt;
    short_r    <= short_nxt;
    out_item_r <= out_item_nxt;
  end

  abra_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(count_r)),
    .wdata (wr_ent),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
